[hdl/mtsm_pkg.sv]
// ----------------------------------------------------------------------------
// mtsm_pkg
// Shared widths, reset values, register codes and controller/datapath
// command and status bundles for the stack median block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsm_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 20;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned CENTER_W = 16;
    localparam int unsigned RSQ_W    = 33;
    localparam int unsigned MEDIAN_W = 21;

    // disk test arithmetic
    localparam int unsigned DIFF_W = COORD_W + 5;   // 16*pixel - center, signed
    localparam int unsigned SQ_W   = 32;            // one squared offset

    // configuration port
    localparam int unsigned APB_DW = 64;
    localparam int unsigned APB_AW = 5;

    // default parameter values
    localparam int unsigned DEF_MAX_SAMPLES = 64;
    localparam int unsigned DEF_IMAGE_SIZE  = 4096;

    // register reset values
    localparam logic signed [SAMPLE_W-1:0] CUTOFF_RESET   = 20'sd4800;  // 300.0 G
    localparam logic [CENTER_W-1:0]        CENTER_RESET   = 16'd32752;
    localparam logic [RSQ_W-1:0]           RADIUS_SQ_RESET = '0;

    // register index (paddr[4:3])
    typedef enum logic [1:0] {
        REG_CUTOFF    = 2'd0,
        REG_CENTER_X  = 2'd1,
        REG_CENTER_Y  = 2'd2,
        REG_RADIUS_SQ = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cutoff;
        logic [CENTER_W-1:0]        center_x;
        logic [CENTER_W-1:0]        center_y;
        logic [RSQ_W-1:0]           radius_sq;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;   // take an item this cycle
        logic count;      // bump seen count
        logic ins_start;  // load insert position, read entry below it
        logic shift;      // move read entry up one, read next lower
        logic place;      // write sample at insert position, bump kept count
        logic rd_mid_hi;  // read upper middle entry, square dx
        logic rd_mid_lo;  // read lower middle entry, square dy
        logic emit;       // load result register, clear counts
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic consider;
        logic keep;
        logic kept_zero;
        logic shift_more;
        logic pos_one;
        logic last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[hdl/mtsm_if.sv]
// ----------------------------------------------------------------------------
// mtsm_sample_if / mtsm_result_if
// Valid/ready channels for incoming samples and outgoing medians.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtsm_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mtsm_pkg::SAMPLE_W-1:0] sample;
    logic [mtsm_pkg::COORD_W-1:0]         pixel_x;
    logic [mtsm_pkg::COORD_W-1:0]         pixel_y;
    logic                                 last_sample;

    modport source (output valid, output sample, output pixel_x, output pixel_y,
                    output last_sample, input ready);
    modport sink   (input valid, input sample, input pixel_x, input pixel_y,
                    input last_sample, output ready);
endinterface

interface mtsm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mtsm_pkg::MEDIAN_W-1:0] median_value;
    logic                                 missing;

    modport source (output valid, output median_value, output missing, input ready);
    modport sink   (input valid, input median_value, input missing, output ready);
endinterface

`default_nettype wire

[hdl/masked_thresholded_stack_median.sv]
// ----------------------------------------------------------------------------
// masked_thresholded_stack_median
// Per-pixel stack median: samples below a cutoff are insertion sorted into
// a store; the closing sample yields the median, or missing when the pixel
// is off the disk, off the image, or no sample was kept.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake        payload
//  ----------  ---  ---------------  ------------------------------------------
//  sample_ch   in   valid / ready    sample, pixel_x, pixel_y, last_sample
//  result_ch   out  valid / ready    median_value, missing
//  APB         in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  Steps: an item passes idle, check and tail; when kept it also shifts
//  each stored entry above it up one (one store read/write each), then is
//  placed. A closing item adds two store reads and the shared squarer.
//  The store has one write and one registered read port; that port bounds
//  the insertion to one shifted entry per cycle.
//  Reset: async, active low; counts clear, registers take reset values.
//  Stalls: the result register holds one result; a closing item waits for it.
//
`default_nettype none

module masked_thresholded_stack_median #(
    parameter int unsigned MAX_SAMPLES = mtsm_pkg::DEF_MAX_SAMPLES,
    parameter int unsigned IMAGE_SIZE  = mtsm_pkg::DEF_IMAGE_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mtsm_sample_if.sink                      sample_ch,
    mtsm_result_if.source                    result_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mtsm_pkg::APB_AW-1:0] paddr,
    input  wire logic [mtsm_pkg::APB_DW-1:0] pwdata,
    output logic      [mtsm_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    mtsm_pkg::cfg_t    cfg;
    mtsm_pkg::cmd_t    cmd;
    mtsm_pkg::status_t status;

    // register file; write it only while no stack is in flight
    mtsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    mtsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // store, counters, disk test, result register
    mtsm_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .IMAGE_SIZE  (IMAGE_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[hdl/mtsm_cfg.sv]
// ----------------------------------------------------------------------------
// mtsm_cfg
// APB register file: cutoff, disk center and squared radius.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mtsm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mtsm_pkg::APB_DW-1:0]   pwdata,
    output logic      [mtsm_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output mtsm_pkg::cfg_t                     cfg
);

    mtsm_pkg::cfg_t     cfg_reg;
    mtsm_pkg::reg_idx_t idx;
    logic               wr;

    assign idx    = mtsm_pkg::reg_idx_t'(paddr[4:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cutoff    <= mtsm_pkg::CUTOFF_RESET;
            cfg_reg.center_x  <= mtsm_pkg::CENTER_RESET;
            cfg_reg.center_y  <= mtsm_pkg::CENTER_RESET;
            cfg_reg.radius_sq <= mtsm_pkg::RADIUS_SQ_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                mtsm_pkg::REG_CUTOFF:    cfg_reg.cutoff    <= pwdata[mtsm_pkg::SAMPLE_W-1:0];
                mtsm_pkg::REG_CENTER_X:  cfg_reg.center_x  <= pwdata[mtsm_pkg::CENTER_W-1:0];
                mtsm_pkg::REG_CENTER_Y:  cfg_reg.center_y  <= pwdata[mtsm_pkg::CENTER_W-1:0];
                mtsm_pkg::REG_RADIUS_SQ: cfg_reg.radius_sq <= pwdata[mtsm_pkg::RSQ_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            mtsm_pkg::REG_CUTOFF:    prdata[mtsm_pkg::SAMPLE_W-1:0] = cfg_reg.cutoff;
            mtsm_pkg::REG_CENTER_X:  prdata[mtsm_pkg::CENTER_W-1:0] = cfg_reg.center_x;
            mtsm_pkg::REG_CENTER_Y:  prdata[mtsm_pkg::CENTER_W-1:0] = cfg_reg.center_y;
            mtsm_pkg::REG_RADIUS_SQ: prdata[mtsm_pkg::RSQ_W-1:0]    = cfg_reg.radius_sq;
        endcase
    end

endmodule

`default_nettype wire

[hdl/mtsm_ctrl.sv]
// ----------------------------------------------------------------------------
// mtsm_ctrl
// Sequencer: take item, insertion sort into the store, close the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  mtsm_pkg::status_t     status,
    output mtsm_pkg::cmd_t        cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_PLACE = 7'b0001000,
        S_TAIL  = 7'b0010000,
        S_MED1  = 7'b0100000,
        S_MED2  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.count = status.consider;
                if (status.keep)
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = status.kept_zero ? S_PLACE : S_SHIFT;
                end
                else
                    state_next = S_TAIL;
            end
            S_SHIFT:
            begin
                if (status.shift_more)
                begin
                    cmd.shift = 1'b1;
                    if (status.pos_one)
                        state_next = S_PLACE;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_TAIL;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                if (status.last)
                begin
                    cmd.rd_mid_hi = 1'b1;
                    state_next    = S_MED1;
                end
                else
                    state_next = S_IDLE;
            end
            S_MED1:
            begin
                cmd.rd_mid_lo = 1'b1;
                state_next    = S_MED2;
            end
            S_MED2:
            begin
                // hold here until the result register is free
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/mtsm_dp.sv]
// ----------------------------------------------------------------------------
// mtsm_dp
// Datapath: item registers, counters, sorted sample store, disk test
// multiplier, median add and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsm_dp #(
    parameter int unsigned MAX_SAMPLES = mtsm_pkg::DEF_MAX_SAMPLES,
    parameter int unsigned IMAGE_SIZE  = mtsm_pkg::DEF_IMAGE_SIZE
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mtsm_sample_if.sink        sample_ch,
    mtsm_result_if.source      result_ch,
    input  mtsm_pkg::cfg_t     cfg,
    input  mtsm_pkg::cmd_t     cmd,
    output mtsm_pkg::status_t  status
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
    localparam int unsigned SW    = mtsm_pkg::SAMPLE_W;
    localparam int unsigned DW    = mtsm_pkg::DIFF_W;
    localparam int unsigned QW    = mtsm_pkg::SQ_W;
    localparam int unsigned MW    = mtsm_pkg::MEDIAN_W;
    localparam int unsigned RW    = mtsm_pkg::RSQ_W;

    // item
    logic signed [SW-1:0]               sample_reg;
    logic [mtsm_pkg::COORD_W-1:0]       px_reg;
    logic [mtsm_pkg::COORD_W-1:0]       py_reg;
    logic                               last_reg;
    logic                               take;

    // counters
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] kept_idx;
    logic [CNT_W-1:0] half_cnt;
    logic [IDX_W-1:0] half_idx;

    // store
    logic signed [SW-1:0] mem [MAX_SAMPLES];
    logic signed [SW-1:0] rd_data_reg;
    logic signed [SW-1:0] mid_hi_reg;
    logic signed [SW-1:0] wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 rd_en;
    logic                 wr_en;

    // disk test
    logic signed [DW-1:0]     dx, dy, mul_op;
    logic signed [2*DW-1:0]   prod;
    logic [QW-1:0]            sq_a_reg, sq_b_reg;
    logic [RW-1:0]            dist_sq;
    logic                     off_disk, off_img, missing_w;
    logic signed [MW-1:0]     median_w;

    // result register
    logic                 out_valid_reg;
    logic signed [MW-1:0] median_reg;
    logic                 missing_reg;

    assign take            = cmd.in_ready && sample_ch.valid;
    assign sample_ch.ready = cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample_ch.sample;
            px_reg     <= sample_ch.pixel_x;
            py_reg     <= sample_ch.pixel_y;
            last_reg   <= sample_ch.last_sample;
        end
    end

    // ---- counters ----
    assign kept_idx = kept_reg[IDX_W-1:0];
    assign half_cnt = kept_reg >> 1;
    assign half_idx = half_cnt[IDX_W-1:0];

    always_comb
    begin
        seen_next = seen_reg;
        kept_next = kept_reg;
        pos_next  = pos_reg;
        if (cmd.count)
            seen_next = seen_reg + CNT_W'(1);
        if (cmd.place)
            kept_next = kept_reg + CNT_W'(1);
        if (cmd.emit)
        begin
            seen_next = '0;
            kept_next = '0;
        end
        if (cmd.ins_start)
            pos_next = kept_idx;
        else if (cmd.shift)
            pos_next = pos_reg - IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            kept_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            kept_reg <= kept_next;
            pos_reg  <= pos_next;
        end
    end

    // ---- sorted store: one write, one registered read per cycle ----
    assign wr_en   = cmd.shift || cmd.place;
    assign wr_data = cmd.shift ? rd_data_reg : sample_reg;
    assign rd_en   = cmd.ins_start || cmd.shift || cmd.rd_mid_hi || cmd.rd_mid_lo;

    always_comb
    begin
        rd_addr = '0;
        if (cmd.ins_start)
            rd_addr = kept_idx - IDX_W'(1);
        else if (cmd.shift)
            rd_addr = pos_reg - IDX_W'(2);
        else if (cmd.rd_mid_hi)
            rd_addr = half_idx;
        else if (cmd.rd_mid_lo)
            rd_addr = half_idx - IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[pos_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.rd_mid_lo)
            mid_hi_reg <= rd_data_reg;
    end

    // ---- disk test: one squarer shared by dx and dy ----
    assign dx = $signed({1'b0, px_reg, 4'b0000}) - $signed({1'b0, cfg.center_x});
    assign dy = $signed({1'b0, py_reg, 4'b0000}) - $signed({1'b0, cfg.center_y});
    assign mul_op = cmd.rd_mid_lo ? dy : dx;
    assign prod   = mul_op * mul_op;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_mid_hi)
            sq_a_reg <= prod[QW-1:0];
        if (cmd.rd_mid_lo)
            sq_b_reg <= prod[QW-1:0];
    end

    assign dist_sq   = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};
    assign off_disk  = dist_sq >= cfg.radius_sq;
    assign off_img   = (32'(px_reg) >= 32'(IMAGE_SIZE)) || (32'(py_reg) >= 32'(IMAGE_SIZE));
    assign missing_w = off_disk || off_img || (kept_reg == '0);

    // missing: zero; odd count: twice the middle; even: sum of the two middles
    always_comb
    begin
        if (missing_w)
            median_w = '0;
        else if (kept_reg[0])
            median_w = {mid_hi_reg, 1'b0};
        else
            median_w = MW'(mid_hi_reg) + MW'(rd_data_reg);
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            median_reg  <= median_w;
            missing_reg <= missing_w;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.median_value = median_reg;
    assign result_ch.missing      = missing_reg;

    // ---- status ----
    always_comb
    begin
        status            = '0;
        status.in_valid   = sample_ch.valid;
        status.consider   = seen_reg < CNT_W'(MAX_SAMPLES);
        status.keep       = status.consider && (sample_reg < cfg.cutoff)
                            && (kept_reg < CNT_W'(MAX_SAMPLES));
        status.kept_zero  = kept_reg == '0;
        status.shift_more = rd_data_reg > sample_reg;
        status.pos_one    = pos_reg == IDX_W'(1);
        status.last       = last_reg;
        status.out_free   = !out_valid_reg || result_ch.ready;
    end

endmodule

`default_nettype wire
